### hw/rtl/vdbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdbt_pkg: shared types and constants for virtual disk block translation
// Request codes, image modes, status codes, register indexes, sequencer
// states and the small block-size helpers.
// ----------------------------------------------------------------------------
package vdbt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);
   localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);

   localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
   localparam logic [16:0] MAX_SPB   = 17'd65536;
   localparam logic [13:0] SECT_RND  = 14'd511;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_RSVD  = 2'd3;

   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_FIXED = 2'd1;
   localparam logic [1:0] MODE_DYN   = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNALLOC = 2'd1;
   localparam logic [1:0] STAT_RANGE   = 2'd2;
   localparam logic [1:0] STAT_OVF     = 2'd3;

   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_SPB     = 2'd1;
   localparam logic [1:0] CSR_ENTRIES = 2'd2;
   localparam logic [1:0] CSR_APPEND  = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_LOOK,
      ST_ALLOC,
      ST_SUM1,
      ST_SUM2,
      ST_DONE
   } state_type;

   function automatic logic [16:0] spb_clamp(input logic [16:0] spb);
      logic [16:0] r;
      r = spb;
      if (spb == 17'd0) begin
         r = 17'd1;
      end else if (spb > MAX_SPB) begin
         r = MAX_SPB;
      end
      return r;
   endfunction

   function automatic logic [4:0] bitmap_sectors(input logic [16:0] spb);
      logic [13:0] s;
      s = spb[16:3] + SECT_RND;
      return s[13:9];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/virtual_disk_block_translation_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// virtual_disk_block_translation_core: logical to image sector translation
// Raw, fixed and dynamic image modes with a block table, append allocation
// and a shared add/subtract unit driven by a small sequencer.
// ----------------------------------------------------------------------------
// Load, reserved, raw and fixed requests go straight to ST_DONE, which registers the result
// when the output is free; dynamic ones first run the restoring division of lba by
// sectors_per_block, one quotient bit per cycle, then ST_CHECK, ST_LOOK, ST_ALLOC on an
// allocation and ST_SUM1, ST_SUM2, leaving early for ST_DONE on an error.
// One request at a time; the next is taken in the cycle after the result is registered.
// Reset: a pass marks all 1024 table entries free; requests stall, config writes are taken.
module virtual_disk_block_translation_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_lba,
   input  wire logic [9:0]  req_table_index,
   input  wire logic [31:0] req_table_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [32:0]      rsp_image_sector,
   output logic             rsp_newly_allocated,
   output logic [31:0]      rsp_block_start_sector
);
   import vdbt_pkg::*;

   state_type          state_ff, state_in;
   logic [TBL_AW-1:0]  clr_ff, clr_in;
   logic [4:0]         cnt_ff, cnt_in;

   logic [1:0]         mode_ff, mode_in;
   logic [16:0]        spb_cfg_ff, spb_cfg_in;
   logic [10:0]        entries_ff, entries_in;
   logic [31:0]        nfs_ff, nfs_in;

   logic [1:0]         type_ff, type_in;
   logic [31:0]        q_ff, q_in;
   logic [16:0]        rem_ff, rem_in;
   logic [16:0]        spb_ff, spb_in;
   logic [4:0]         bitmap_ff, bitmap_in;
   logic [17:0]        span_ff, span_in;
   logic [31:0]        entry_ff, entry_in;
   logic [32:0]        acc_ff, acc_in;
   logic               new_ff, new_in;
   logic [1:0]         status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [32:0]        rsp_sector_ff, rsp_sector_in;
   logic               rsp_new_ff, rsp_new_in;
   logic [31:0]        rsp_start_ff, rsp_start_in;

   logic [31:0]        tbl_mem [TABLE_DEPTH];
   logic [31:0]        rd_ff;

   logic               accept;
   logic               out_go;
   logic [32:0]        alu_a, alu_b;
   logic               alu_sub;
   logic [33:0]        alu_res;
   logic               mem_we;
   logic [TBL_AW-1:0]  mem_waddr;
   logic [31:0]        mem_wdata;
   logic [17:0]        trial;
   logic               div_ge;
   logic [TBL_CW-1:0]  limit;
   logic               load_bad;

   assign accept   = req_valid && !req_stall;
   assign out_go   = !rsp_valid_ff || !rsp_stall;
   assign trial    = {rem_ff, q_ff[31]};
   assign alu_res  = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});
   assign div_ge   = !alu_res[33];
   assign limit    = (32'(entries_ff) > 32'(TABLE_DEPTH)) ? TBL_CW'(TABLE_DEPTH)
                                                         : TBL_CW'(entries_ff);
   assign load_bad = 32'(req_table_index) >= 32'(TABLE_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == TBL_AW'(TABLE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD || req_type == REQ_RSVD) begin
                  state_in = ST_DONE;
               end else if (mode_ff == MODE_DYN) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == 5'd31) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (q_ff >= 32'(limit)) ? ST_DONE : ST_LOOK;
         end
         ST_LOOK: begin
            if (rd_ff == FREE_MARK) begin
               state_in = (type_ff == REQ_READ) ? ST_DONE : ST_ALLOC;
            end else begin
               state_in = ST_SUM1;
            end
         end
         ST_ALLOC: begin
            state_in = alu_res[32] ? ST_DONE : ST_SUM1;
         end
         ST_SUM1: state_in = ST_SUM2;
         ST_SUM2: state_in = ST_DONE;
         ST_DONE: begin
            if (out_go) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control outputs: shared unit operands and table write port
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      alu_a     = 33'(req_lba);
      alu_b     = 33'd1;
      alu_sub   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = req_table_index[TBL_AW-1:0];
      mem_wdata = req_table_value;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = FREE_MARK;
         end
         ST_IDLE: begin
            mem_we = accept && (req_type == REQ_LOAD) && !load_bad;
         end
         ST_DIV: begin
            alu_a   = 33'(trial);
            alu_b   = 33'(spb_ff);
            alu_sub = 1'b1;
         end
         ST_ALLOC: begin
            alu_a     = 33'(nfs_ff);
            alu_b     = 33'(span_ff);
            mem_we    = !alu_res[32];
            mem_waddr = q_ff[TBL_AW-1:0];
            mem_wdata = nfs_ff;
         end
         ST_SUM1: begin
            alu_a = 33'(entry_ff);
            alu_b = 33'(bitmap_ff);
         end
         ST_SUM2: begin
            alu_a = acc_ff;
            alu_b = 33'(rem_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      mode_in       = mode_ff;
      spb_cfg_in    = spb_cfg_ff;
      entries_in    = entries_ff;
      nfs_in        = nfs_ff;
      type_in       = type_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      spb_in        = spb_ff;
      bitmap_in     = bitmap_ff;
      span_in       = span_ff;
      entry_in      = entry_ff;
      acc_in        = acc_ff;
      new_in        = new_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_sector_in = rsp_sector_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_start_in  = rsp_start_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MODE:    mode_in    = csr_wdata[1:0];
            CSR_SPB:     spb_cfg_in = csr_wdata[16:0];
            CSR_ENTRIES: entries_in = csr_wdata[10:0];
            CSR_APPEND: begin
               nfs_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + TBL_AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               type_in   = req_type;
               q_in      = req_lba;
               rem_in    = 17'd0;
               cnt_in    = 5'd0;
               spb_in    = spb_clamp(spb_cfg_ff);
               new_in    = 1'b0;
               status_in = STAT_OK;
               entry_in  = 32'd0;
               acc_in    = 33'd0;
               if (req_type == REQ_LOAD) begin
                  if (load_bad) status_in = STAT_RANGE;
               end else if (req_type == REQ_RSVD) begin
                  acc_in = 33'd0;
               end else if (mode_ff == MODE_FIXED) begin
                  acc_in = alu_res[32:0];
               end else if (mode_ff != MODE_DYN) begin
                  acc_in = 33'(req_lba);
               end
            end
         end
         ST_DIV: begin
            q_in      = {q_ff[30:0], div_ge};
            rem_in    = div_ge ? alu_res[16:0] : trial[16:0];
            cnt_in    = cnt_ff + 5'd1;
            bitmap_in = bitmap_sectors(spb_ff);
            span_in   = 18'(spb_ff) + 18'(bitmap_in);
         end
         ST_CHECK: begin
            if (q_ff >= 32'(limit)) status_in = STAT_RANGE;
         end
         ST_LOOK: begin
            if (rd_ff == FREE_MARK) begin
               if (type_ff == REQ_READ) status_in = STAT_UNALLOC;
            end else begin
               entry_in = rd_ff;
            end
         end
         ST_ALLOC: begin
            if (alu_res[32]) begin
               status_in = STAT_OVF;
            end else begin
               entry_in = nfs_ff;
               new_in   = 1'b1;
               nfs_in   = alu_res[31:0];
            end
         end
         ST_SUM1: acc_in = alu_res[32:0];
         ST_SUM2: acc_in = alu_res[32:0];
         ST_DONE: begin
            if (out_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_sector_in = acc_ff;
               rsp_new_in    = new_ff;
               rsp_start_in  = entry_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         mode_ff      <= MODE_RAW;
         spb_cfg_ff   <= 17'd4096;
         entries_ff   <= '0;
         nfs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         spb_cfg_ff   <= spb_cfg_in;
         entries_ff   <= entries_in;
         nfs_ff       <= nfs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      spb_ff        <= spb_in;
      bitmap_ff     <= bitmap_in;
      span_ff       <= span_in;
      entry_ff      <= entry_in;
      acc_ff        <= acc_in;
      new_ff        <= new_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_start_ff  <= rsp_start_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) tbl_mem[mem_waddr] <= mem_wdata;
      rd_ff <= tbl_mem[q_ff[TBL_AW-1:0]];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_image_sector       = rsp_sector_ff;
   assign rsp_newly_allocated    = rsp_new_ff;
   assign rsp_block_start_sector = rsp_start_ff;

   a_new_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newly_allocated |-> rsp_status == STAT_OK)
      else $error("allocation reported with error status");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_image_sector == 33'd0 && rsp_block_start_sector == 32'd0)
      else $error("nonzero sector on error status");

   a_nfs_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_ALLOC && !(csr_we && csr_index == CSR_APPEND) |=> $stable(nfs_ff))
      else $error("append pointer moved without allocation");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff == 5'd31 |=> state_ff == ST_CHECK)
      else $error("division did not end after 32 steps");

endmodule
`default_nettype wire
